[hw/rtl/sdwq_pkg.sv]
// shared constants, types and codes of the sorted delay wake queue
package sdwq_pkg;

  localparam int unsigned TASK_W        = 4;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned NUM_IDS       = 1 << TASK_W;
  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned S_TDATA_W     = 72;
  localparam int unsigned M_TDATA_W     = 8;

  localparam logic ACT_DELAY = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INSERT = 4'b0010,
    ST_ROTATE = 4'b0100,
    ST_WAKE   = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic rot;
    logic ins;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic place;
    logic r_zero;
    logic due;
    logic out_free;
    logic pop_last;
  } status_t;

endpackage

[hw/rtl/sorted_delay_wake_queue.sv]
// top level of the sorted delay wake queue
//
// keeps sleeping tasks in a list sorted by wake time, earlier inserts first
// among equal wake times
// input channel s_*: s_tuser_i is the action (0 delay, 1 tick check);
//   a delay item stores task_id with wake time now_tick + sleep_ticks and
//   gives no output; a delay for a task already queued, or with the list
//   full, is dropped
// output channel m_*: one item per woken task, m_tlast_o on the final one
//   of a tick check; a tick check that wakes nothing gives no item
// one item is worked on at a time; s_tready_o is high only while idle
// a delay item rotates each entry ahead of its place from the head to the
//   tail, appends at the tail, then moves the entries behind it from the head
//   to the tail as well (the list is rotated through the head slot); a dropped
//   delay leaves the list as it is; a tick check pops the due tasks from the
//   head in turn, and the output register lets the next input item be taken
//   while the final woken task waits
// when the receiver stalls, popping waits and the output register holds
// reset empties the list at once; no clearing pass is needed
module sorted_delay_wake_queue #(
  parameter int unsigned MAX_TASKS = sdwq_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [sdwq_pkg::S_TDATA_W-1:0] s_tdata_i,  // task_id, sleep_ticks, now_tick, pad
  input  logic                           s_tuser_i,  // action
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [sdwq_pkg::M_TDATA_W-1:0] m_tdata_o,  // woken_task, pad
  output logic                           m_tlast_o   // last
);

  sdwq_pkg::cmd_t              cmd;
  sdwq_pkg::status_t           status;
  logic [sdwq_pkg::TASK_W-1:0] woken_task;

  sdwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .action_i   (s_tuser_i),
    .status_i   (status),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd)
  );

  sdwq_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .task_id_i     (s_tdata_i[3:0]),
    .sleep_ticks_i (s_tdata_i[35:4]),
    .now_tick_i    (s_tdata_i[67:36]),
    .m_tready_i    (m_tready_i),
    .status_o      (status),
    .m_tvalid_o    (m_tvalid_o),
    .woken_task_o  (woken_task),
    .m_tlast_o     (m_tlast_o)
  );

  assign m_tdata_o = {{(sdwq_pkg::M_TDATA_W - sdwq_pkg::TASK_W){1'b0}}, woken_task};

endmodule

[hw/rtl/sdwq_ctrl.sv]
// controller state machine of the sorted delay wake queue
module sdwq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              action_i,
  input  sdwq_pkg::status_t status_i,
  output logic              s_tready_o,
  output sdwq_pkg::cmd_t    cmd_o
);

  sdwq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdwq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      sdwq_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d = (action_i == sdwq_pkg::ACT_TICK) ? sdwq_pkg::ST_WAKE
                                                     : sdwq_pkg::ST_INSERT;
        end
      end
      sdwq_pkg::ST_INSERT: begin
        if (status_i.drop) begin
          state_d = sdwq_pkg::ST_IDLE;
        end else if (status_i.place) begin
          cmd_o.ins = 1'b1;
          state_d = status_i.r_zero ? sdwq_pkg::ST_IDLE : sdwq_pkg::ST_ROTATE;
        end else begin
          cmd_o.rot = 1'b1;
        end
      end
      sdwq_pkg::ST_ROTATE: begin
        if (status_i.r_zero) begin
          state_d = sdwq_pkg::ST_IDLE;
        end else begin
          cmd_o.rot = 1'b1;
        end
      end
      sdwq_pkg::ST_WAKE: begin
        if (!status_i.due) begin
          state_d = sdwq_pkg::ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.pop = 1'b1;
          if (status_i.pop_last) begin
            state_d = sdwq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sdwq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/sdwq_dpath.sv]
// sorted list storage, counters and output register of the wake queue
module sdwq_dpath #(
  parameter int unsigned MAX_TASKS = sdwq_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sdwq_pkg::cmd_t              cmd_i,
  input  logic [sdwq_pkg::TASK_W-1:0] task_id_i,
  input  logic [sdwq_pkg::TIME_W-1:0] sleep_ticks_i,
  input  logic [sdwq_pkg::TIME_W-1:0] now_tick_i,
  input  logic                        m_tready_i,
  output sdwq_pkg::status_t           status_o,
  output logic                        m_tvalid_o,
  output logic [sdwq_pkg::TASK_W-1:0] woken_task_o,
  output logic                        m_tlast_o
);

  localparam int unsigned IdxW = $clog2(MAX_TASKS);
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

  logic [sdwq_pkg::TASK_W-1:0]  slot_task_q [MAX_TASKS];
  logic [sdwq_pkg::TIME_W-1:0]  slot_wake_q [MAX_TASKS];
  logic [sdwq_pkg::TASK_W-1:0]  nxt_task    [MAX_TASKS];
  logic [sdwq_pkg::TIME_W-1:0]  nxt_wake    [MAX_TASKS];

  logic [CntW-1:0]              cnt_q, r_q, cnt_m1;
  logic [IdxW-1:0]              tail_idx, ins_idx;
  logic [sdwq_pkg::TASK_W-1:0]  task_q;
  logic [sdwq_pkg::TIME_W-1:0]  wake_q, now_q;
  logic [sdwq_pkg::NUM_IDS-1:0] present_q;
  logic                         out_valid_q, out_last_q;
  logic [sdwq_pkg::TASK_W-1:0]  out_task_q;

  assign cnt_m1   = cnt_q - CntW'(1);
  assign tail_idx = cnt_m1[IdxW-1:0];
  assign ins_idx  = cnt_q[IdxW-1:0];

  // status toward the controller
  assign status_o.drop     = (cnt_q == CntW'(MAX_TASKS)) || present_q[task_q];
  assign status_o.r_zero   = (r_q == '0);
  assign status_o.place    = (r_q == '0) || (slot_wake_q[0] > wake_q);
  assign status_o.due      = (cnt_q != '0) && (slot_wake_q[0] <= now_q);
  assign status_o.out_free = !out_valid_q || m_tready_i;
  assign status_o.pop_last = (cnt_q == CntW'(1)) || (slot_wake_q[1] > now_q);

  // latched item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      task_q <= task_id_i;
      wake_q <= now_tick_i + sleep_ticks_i;
      now_q  <= now_tick_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      r_q       <= '0;
      present_q <= '0;
    end else begin
      if (cmd_i.load) begin
        r_q <= cnt_q;
      end else if (cmd_i.rot) begin
        r_q <= r_q - CntW'(1);
      end
      if (cmd_i.ins) begin
        cnt_q             <= cnt_q + CntW'(1);
        present_q[task_q] <= 1'b1;
      end else if (cmd_i.pop) begin
        cnt_q                     <= cnt_m1;
        present_q[slot_task_q[0]] <= 1'b0;
      end
    end
  end

  // list slots: shift toward the head, wrap the head to the tail, append
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_slot
    if (i < MAX_TASKS - 1) begin : g_shift
      assign nxt_task[i] = slot_task_q[i+1];
      assign nxt_wake[i] = slot_wake_q[i+1];
    end else begin : g_end
      assign nxt_task[i] = slot_task_q[i];
      assign nxt_wake[i] = slot_wake_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.ins && (ins_idx == IdxW'(i))) begin
        slot_task_q[i] <= task_q;
        slot_wake_q[i] <= wake_q;
      end else if (cmd_i.rot && (tail_idx == IdxW'(i))) begin
        slot_task_q[i] <= slot_task_q[0];
        slot_wake_q[i] <= slot_wake_q[0];
      end else if (cmd_i.rot || cmd_i.pop) begin
        slot_task_q[i] <= nxt_task[i];
        slot_wake_q[i] <= nxt_wake[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pop) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      out_task_q <= slot_task_q[0];
      out_last_q <= status_o.pop_last;
    end
  end

  assign m_tvalid_o   = out_valid_q;
  assign woken_task_o = out_task_q;
  assign m_tlast_o    = out_last_q;

endmodule

[hw/rtl/sdwq_checker.sv]
// port-level checks of the sorted delay wake queue and their binding
module sdwq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_tvalid_i,
  input logic                           s_tready_o,
  input logic [sdwq_pkg::S_TDATA_W-1:0] s_tdata_i,
  input logic                           s_tuser_i,
  input logic                           m_tvalid_o,
  input logic                           m_tready_i,
  input logic [sdwq_pkg::M_TDATA_W-1:0] m_tdata_o,
  input logic                           m_tlast_o
);

  logic s_acc;
  assign s_acc = s_tvalid_i && s_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("stalled output item changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_tready_o)
    else $error("input taken while an item is in work");

  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tlast_o |-> !s_tready_o)
    else $error("input taken in the middle of a wake run");

  a_delay_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_tuser_i == sdwq_pkg::ACT_DELAY) && !m_tvalid_o |=> !m_tvalid_o)
    else $error("delay item produced an output item");

endmodule

bind sorted_delay_wake_queue sdwq_checker u_sdwq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tdata_i  (s_tdata_i),
  .s_tuser_i  (s_tuser_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tlast_o  (m_tlast_o)
);
